@@ rtl/atrp_pkg.sv @@
// shared types, constants and helper functions for the accelerometer tilt block
`default_nettype none
package atrp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    localparam int VEC_W  = 36;
    localparam int ANG_W  = 28;
    localparam int SIDE_W = 28;
    localparam int RES_W  = 18;
    localparam int ANG_SHIFT = 12;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;
    localparam logic signed [ANG_W-1:0] ROLL_BASE_Q = 28'sd73728000;
    localparam logic signed [RES_W-1:0] ROLL_LIM  = 18'sd18000;
    localparam logic signed [RES_W-1:0] PITCH_LIM = 18'sd9000;

    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic        [SIDE_W-1:0] t_side;
    typedef logic signed [RES_W-1:0]  t_res;

    typedef enum logic [1:0] {
        BASE_NONE = 2'b00,
        BASE_POS  = 2'b01,
        BASE_NEG  = 2'b10
    } t_base;

    typedef struct packed {
        logic signed [15:0]      ax;
        logic signed [ANG_W-1:0] roll;
    } t_gside;

    function automatic t_ang atan_val(input int idx);
        t_ang v;
        case (idx)
            0:  v = 28'sd18432000;
            1:  v = 28'sd10881045;
            2:  v = 28'sd5749245;
            3:  v = 28'sd2918407;
            4:  v = 28'sd1464867;
            5:  v = 28'sd733147;
            6:  v = 28'sd366663;
            7:  v = 28'sd183343;
            8:  v = 28'sd91673;
            9:  v = 28'sd45837;
            10: v = 28'sd22918;
            11: v = 28'sd11459;
            12: v = 28'sd5730;
            13: v = 28'sd2865;
            14: v = 28'sd1432;
            15: v = 28'sd716;
            16: v = 28'sd358;
            17: v = 28'sd179;
            18: v = 28'sd90;
            19: v = 28'sd45;
            20: v = 28'sd22;
            21: v = 28'sd11;
            22: v = 28'sd6;
            23: v = 28'sd3;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_res round_clamp(input t_ang a, input t_res lim);
        logic signed [ANG_W:0] mag;
        logic signed [ANG_W:0] q;
        logic signed [ANG_W:0] w;
        t_res r;
        mag = a[ANG_W-1] ? -(29'(a)) : 29'(a);
        q = (mag + 29'sd2048) >>> ANG_SHIFT;
        w = a[ANG_W-1] ? -q : q;
        r = w[RES_W-1:0];
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/accel_tilt_roll_pitch.sv @@
// top level: roll and pitch tilt angles from one accelerometer sample
// path: roll cordic, gain compensation, pitch cordic, then the output register
// throughput: one sample per cycle while the output is not stalled, set by one cordic iteration per pipeline stage
// the whole pipeline advances unless a held result is stalled at the output
// reset clears all valid bits; no state is kept between samples
`default_nettype none
module accel_tilt_roll_pitch import atrp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_roll_centideg,
    output logic signed [14:0]      o_pitch_centideg
);

    logic               en;
    logic signed [16:0] ay17;
    logic signed [16:0] az17;
    logic signed [16:0] rx0;
    logic signed [16:0] ry0;
    t_base              base_in;
    t_vec               roll_x_in;
    t_vec               roll_y_in;
    t_side              roll_side_in;

    logic               roll_v;
    t_vec               roll_x;
    t_ang               roll_z;
    t_side              roll_side;
    t_base              roll_base;
    t_ang               roll_a;
    t_gside             gside_in;

    logic               gain_v;
    t_vec               gain_mag;
    t_gside             gain_side;
    logic signed [16:0] pitch_y17;
    t_vec               pitch_y_in;

    logic               pitch_v;
    t_ang               pitch_z;
    t_side              pitch_side;

    logic               r_out_valid;
    logic signed [15:0] r_roll;
    logic signed [14:0] r_pitch;
    t_res               n_roll;
    t_res               n_pitch;

    assign o_stall = r_out_valid && i_stall;
    assign en      = !o_stall;

    always_comb begin
        ay17 = 17'(i_accel_y);
        az17 = 17'(i_accel_z);
        if (i_accel_z[15]) begin
            rx0     = -az17;
            ry0     = -ay17;
            base_in = i_accel_y[15] ? BASE_NEG : BASE_POS;
        end else begin
            rx0     = az17;
            ry0     = ay17;
            base_in = BASE_NONE;
        end
        roll_x_in    = {{(VEC_W-33){rx0[16]}}, rx0, 16'b0};
        roll_y_in    = {{(VEC_W-33){ry0[16]}}, ry0, 16'b0};
        roll_side_in = {{(SIDE_W-18){1'b0}}, i_accel_x, base_in};
    end

    atrp_vector u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_x     (roll_x_in),
        .i_y     (roll_y_in),
        .i_side  (roll_side_in),
        .o_valid (roll_v),
        .o_x     (roll_x),
        .o_z     (roll_z),
        .o_side  (roll_side)
    );

    always_comb begin
        roll_base = t_base'(roll_side[1:0]);
        case (roll_base)
            BASE_POS: roll_a = roll_z + ROLL_BASE_Q;
            BASE_NEG: roll_a = roll_z - ROLL_BASE_Q;
            default:  roll_a = roll_z;
        endcase
        gside_in.ax   = roll_side[17:2];
        gside_in.roll = roll_a;
    end

    atrp_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (roll_v),
        .i_x     (roll_x),
        .i_side  (gside_in),
        .o_valid (gain_v),
        .o_mag   (gain_mag),
        .o_side  (gain_side)
    );

    assign pitch_y17  = -(17'(gain_side.ax));
    assign pitch_y_in = {{(VEC_W-33){pitch_y17[16]}}, pitch_y17, 16'b0};

    atrp_vector u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (gain_v),
        .i_x     (gain_mag),
        .i_y     (pitch_y_in),
        .i_side  (t_side'(gain_side.roll)),
        .o_valid (pitch_v),
        .o_x     (),
        .o_z     (pitch_z),
        .o_side  (pitch_side)
    );

    assign n_roll  = round_clamp(t_ang'(pitch_side[ANG_W-1:0]), ROLL_LIM);
    assign n_pitch = round_clamp(pitch_z, PITCH_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= pitch_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= n_roll[15:0];
            r_pitch <= n_pitch[14:0];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_roll_centideg  = r_roll;
    assign o_pitch_centideg = r_pitch;

endmodule
`default_nettype wire

@@ rtl/atrp_vector.sv @@
// pipelined cordic vectoring unit: an input register, then one iteration per register stage
`default_nettype none
module atrp_vector import atrp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_vec  i_x,
    input  wire t_vec  i_y,
    input  wire t_side i_side,
    output logic       o_valid,
    output t_vec       o_x,
    output t_ang       o_z,
    output t_side      o_side
);

    logic  r_v  [0:NSTEPS];
    logic  r_zf [0:NSTEPS];
    t_vec  r_x  [0:NSTEPS];
    t_vec  r_y  [0:NSTEPS];
    t_ang  r_z  [0:NSTEPS];
    t_side r_s  [0:NSTEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= i_x;
            r_y[0]  <= i_y;
            r_z[0]  <= '0;
            r_zf[0] <= (i_y == '0);
            r_s[0]  <= i_side;
        end
    end

    for (genvar i = 0; i < NSTEPS; i++) begin : g_step
        t_vec n_x;
        t_vec n_y;
        t_ang n_z;

        always_comb begin
            if (r_zf[i]) begin
                n_x = r_x[i];
                n_y = r_y[i];
                n_z = r_z[i];
            end else if (!r_y[i][VEC_W-1]) begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + atan_val(i);
            end else begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - atan_val(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]  <= n_x;
                r_y[i+1]  <= n_y;
                r_z[i+1]  <= n_z;
                r_zf[i+1] <= r_zf[i];
                r_s[i+1]  <= r_s[i];
            end
        end
    end

    assign o_valid = r_v[NSTEPS];
    assign o_x     = r_x[NSTEPS];
    assign o_z     = r_z[NSTEPS];
    assign o_side  = r_s[NSTEPS];

endmodule
`default_nettype wire

@@ rtl/atrp_gain.sv @@
// two stage gain compensation multiply of the cordic magnitude
`default_nettype none
module atrp_gain import atrp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_vec   i_x,
    input  wire t_gside i_side,
    output logic        o_valid,
    output t_vec        o_mag,
    output t_gside      o_side
);

    logic        r_v1;
    logic        r_v2;
    logic [46:0] r_ph;
    logic [46:0] r_pl;
    t_gside      r_s1;
    t_gside      r_s2;
    t_vec        r_mag;
    logic [64:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign n_sum = {1'b0, r_ph, 17'b0} + {18'b0, r_pl};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph  <= 47'(i_x[33:17]) * 47'(INV_GAIN_Q30);
            r_pl  <= 47'(i_x[16:0]) * 47'(INV_GAIN_Q30);
            r_s1  <= i_side;
            r_mag <= {1'b0, n_sum[64:30]};
            r_s2  <= r_s1;
        end
    end

    assign o_valid = r_v2;
    assign o_mag   = r_mag;
    assign o_side  = r_s2;

endmodule
`default_nettype wire

@@ rtl/atrp_checker.sv @@
// port level checks of the tilt block and their bind to the top level
`default_nettype none
module atrp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic signed [15:0] o_roll_centideg,
    input wire logic signed [14:0] o_pitch_centideg
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_roll_centideg)
            && $stable(o_pitch_centideg))
        else $error("stalled result changed");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_centideg >= -16'sd18000) && (o_roll_centideg <= 16'sd18000))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_centideg >= -15'sd9000) && (o_pitch_centideg <= 15'sd9000))
        else $error("pitch out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_roll_centideg  (o_roll_centideg),
    .o_pitch_centideg (o_pitch_centideg)
);
`default_nettype wire

@@ tb/accel_tilt_roll_pitch_test.sv @@
// testbench for the accelerometer roll and pitch tilt block
`default_nettype none
module accel_tilt_roll_pitch_test;
    import atrp_pkg::*;

    localparam int SAT_ROWS = 22;
    localparam int N_RANDOM = 1300;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN_CYC = 2 * CORDIC_STEPS + 20;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        bit                 known;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
    } t_row;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
    } t_angles;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_accel_x;
    logic signed [15:0] i_accel_y;
    logic signed [15:0] i_accel_z;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_roll_centideg;
    logic signed [14:0] o_pitch_centideg;

    t_angles expected_angles[$];
    t_row    samples[SAT_ROWS];
    int      mismatches;
    int      results_seen;
    int      idle_count;
    bit      quiet_sink;
    bit      feed_done;

    accel_tilt_roll_pitch dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_roll_centideg(o_roll_centideg), .o_pitch_centideg(o_pitch_centideg)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint arc_step(int i);
        case (i)
            0:  return 18432000;  1:  return 10881045; 2:  return 5749245;
            3:  return 2918407;   4:  return 1464867;  5:  return 733147;
            6:  return 366663;    7:  return 183343;   8:  return 91673;
            9:  return 45837;     10: return 22918;    11: return 11459;
            12: return 5730;      13: return 2865;     14: return 1432;
            15: return 716;       16: return 358;      17: return 179;
            18: return 90;        19: return 45;       20: return 22;
            21: return 11;        22: return 6;        23: return 3;
            default: return 0;
        endcase
    endfunction

    function automatic longint rotate_to_axis(inout longint x, input longint y);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (y == 0) return 0;
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + arc_step(i);
            end else begin
                x = x - ys; y = y + xs; z = z - arc_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint to_centideg(longint a, longint lim);
        longint r;
        if (a >= 0) r = (a + 2048) >>> 12;
        else r = -((-a + 2048) >>> 12);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles tilt_of(logic signed [15:0] ax, logic signed [15:0] ay,
                                        logic signed [15:0] az);
        longint x;
        longint y;
        longint base;
        longint roll_a;
        longint pitch_a;
        longint mag;
        t_angles t;
        base = 0;
        if (az < 0) begin
            x = -longint'(az); y = -longint'(ay);
            base = (ay >= 0) ? 18000 : -18000;
        end else begin
            x = az; y = ay;
        end
        x = x <<< 16;
        y = y <<< 16;
        roll_a = rotate_to_axis(x, y) + base * 4096;
        mag = longint'((longint'(x) * 64'd652032875) >> 30);
        y = (-longint'(ax)) <<< 16;
        pitch_a = rotate_to_axis(mag, y);
        t.roll = 16'(to_centideg(roll_a, 18000));
        t.pitch = 15'(to_centideg(pitch_a, 9000));
        return t;
    endfunction

    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az, bit idle_ok);
        while (idle_ok && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_accel_z <= az;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_angles.push_back(tilt_of(ax, ay, az));
    endtask

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return 16'($urandom_range(8)) - 16'sd4;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        samples = '{
            '{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 15'sd0},
            '{16'sd0, 16'sd0, -16'sd100, 1'b1, 16'sd18000, 15'sd0},
            '{16'sd0, 16'sd0, 16'sh8000, 1'b1, 16'sd18000, 15'sd0},
            '{16'sd0, 16'sd0, 16'sd100, 1'b1, 16'sd0, 15'sd0},
            '{16'sd0, 16'sd0, 16'sh7fff, 1'b0, 16'sd0, 15'sd0},
            '{16'sh8000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 15'sd0},
            '{16'sh7fff, 16'sd0, 16'sd0, 1'b0, 16'sd0, 15'sd0},
            '{16'sd0, 16'sh7fff, 16'sd0, 1'b0, 16'sd0, 15'sd0},
            '{16'sd0, 16'sh8000, 16'sd0, 1'b0, 16'sd0, 15'sd0},
            '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 16'sd0, 15'sd0},
            '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 16'sd0, 15'sd0},
            '{16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 16'sd0, 15'sd0},
            '{16'sd0, -16'sd1, -16'sd1, 1'b0, 16'sd0, 15'sd0},
            '{16'sd0, 16'sd1, -16'sd1, 1'b0, 16'sd0, 15'sd0},
            '{16'sd1, 16'sd1, 16'sd1, 1'b0, 16'sd0, 15'sd0},
            '{-16'sd1, -16'sd1, 16'sd1, 1'b0, 16'sd0, 15'sd0},
            '{16'sd1000, 16'sd0, 16'sd16384, 1'b0, 16'sd0, 15'sd0},
            '{16'sd0, 16'sd16384, -16'sd16384, 1'b0, 16'sd0, 15'sd0},
            '{16'sd0, -16'sd16384, -16'sd16384, 1'b0, 16'sd0, 15'sd0},
            '{16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, 16'sd0, 15'sd0},
            '{16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0, 16'sd0, 15'sd0},
            '{16'sd12, 16'sd1, 16'sd0, 1'b0, 16'sd0, 15'sd0}
        };
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_accel_x = '0;
        i_accel_y = '0;
        i_accel_z = '0;
        feed_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < SAT_ROWS; r++) begin
            send_sample(samples[r].ax, samples[r].ay, samples[r].az, 1'b1);
            if (samples[r].known) begin
                expected_angles[$].roll = samples[r].roll;
                expected_angles[$].pitch = samples[r].pitch;
            end
        end
        i_valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
        for (int n = 0; n < N_RANDOM; n++) begin
            send_sample(pick_axis(), pick_axis(), pick_axis(), !(n >= 400 && n < 700));
            if (n == 900) begin
                i_valid <= 1'b0;
                while (expected_angles.size() != 0) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        feed_done = 1'b1;
    end

    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            quiet_sink = results_seen >= 450 && results_seen < 750;
            i_stall <= !quiet_sink && $urandom_range(99) < 10;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (expected_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: roll %0d pitch %0d",
                             o_roll_centideg, o_pitch_centideg);
            end else begin
                if (o_roll_centideg !== expected_angles[0].roll ||
                    o_pitch_centideg !== expected_angles[0].pitch) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected roll %0d pitch %0d, got roll %0d pitch %0d",
                                 expected_angles[0].roll, expected_angles[0].pitch,
                                 o_roll_centideg, o_pitch_centideg);
                end
                void'(expected_angles.pop_front());
            end
        end
    end

    initial begin
        mismatches = 0;
        results_seen = 0;
        idle_count = 0;
        fork
            begin
                wait (feed_done);
                while (expected_angles.size() != 0) @(posedge i_clk);
                repeat (DRAIN_CYC) @(posedge i_clk);
            end
            begin
                forever begin
                    @(posedge i_clk);
                    if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_count = 0;
                    else idle_count++;
                    if (idle_count >= WATCHDOG) break;
                end
                $display("timeout with %0d transactions outstanding", expected_angles.size());
                $display("CHECK FAILED");
                $finish;
            end
        join_any
        $display("checked %0d tilt results from directed extremes and random samples",
                 results_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_angles.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ accel_tilt_roll_pitch.f @@
rtl/atrp_pkg.sv
rtl/atrp_vector.sv
rtl/atrp_gain.sv
rtl/accel_tilt_roll_pitch.sv
rtl/atrp_checker.sv
tb/accel_tilt_roll_pitch_test.sv
